FILE: rtl/inverter_overload_current_limiter_macros.svh
// Assertion macros for the checker of the current limiter.
`ifndef INVERTER_OVERLOAD_CURRENT_LIMITER_MACROS_SVH
`define INVERTER_OVERLOAD_CURRENT_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define OLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define OLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/olc_pkg.sv
`default_nettype none

package olc_pkg;

    localparam int IN_W       = 16;
    localparam int LIMIT_W    = 14;
    localparam int MAG_W      = 16;
    localparam int CNT_W      = 16;
    localparam int DIV_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DIVIDE_COUNT      = 3'd0;
    localparam cfg_idx_t REG_RECOVERY_DELAY    = 3'd1;
    localparam cfg_idx_t REG_FULL_OVERLOAD_END = 3'd2;
    localparam cfg_idx_t REG_MID_OVERLOAD_END  = 3'd3;
    localparam cfg_idx_t REG_LAST_OVERLOAD_END = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/olc_if.sv
`default_nettype none

interface olc_sample_if import olc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] current_d;
    logic signed [IN_W-1:0] current_q;

    modport source (output valid, output current_d, output current_q, input ready);
    modport sink (input valid, input current_d, input current_q, output ready);
endinterface

interface olc_result_if import olc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] current_limit;
    logic [MAG_W-1:0]   current_magnitude;
    logic               in_recovery;
    logic [CNT_W-1:0]   overload_level;

    modport source (output valid, output current_limit, output current_magnitude,
                    output in_recovery, output overload_level, input ready);
    modport sink (input valid, input current_limit, input current_magnitude,
                  input in_recovery, input overload_level, output ready);
endinterface

interface olc_cfg_if import olc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/olc_cmpsub.sv
`default_nettype none

module olc_cmpsub #(
    parameter int W = 32
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic [W-1:0]      diff
);

    logic [W:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign ge        = ~wide_diff[W];
    assign diff      = wide_diff[W-1:0];

endmodule

`default_nettype wire

FILE: rtl/inverter_overload_current_limiter.sv
// A tick without a slow update gives its result in the cycle after transfer, one tick per cycle
// while the result slot is free. A slow-update tick runs the shared compare-subtract unit for
// a 16-step square root and a FRAC_BITS-step divide: it steps through ST_MUL_D, ST_MUL_Q,
// ST_ROOT, ST_SEL, ST_DIV and ST_FIN (the last two only when a divide is needed) to ST_DONE,
// which loads the result once the slot is free; the sample side is not ready meanwhile.
// Reset clears the control state and loads the register defaults and a limit of 2.0 pu.
`default_nettype none

module inverter_overload_current_limiter import olc_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input wire logic   clk,
    input wire logic   rst_n,
    olc_sample_if.sink   sample,
    olc_result_if.source result,
    olc_cfg_if.sink      cfg
);

    localparam int AW = (FRAC_BITS + 20 > 32) ? FRAC_BITS + 20 : 32;
    localparam int LW = FRAC_BITS + 2;
    localparam int CW = $clog2((FRAC_BITS > 16) ? FRAC_BITS : 16) + 1;

    localparam logic [31:0]   THRESH_PU  = 32'((102 * (64'd1 << FRAC_BITS)) / 100);
    localparam logic [LW-1:0] ONE_PU     = LW'(1) << FRAC_BITS;
    localparam logic [LW-1:0] TWO_PU     = ONE_PU << 1;
    localparam logic [LW-1:0] ONEHALF_PU = ONE_PU + (ONE_PU >> 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_D = 3'd1;
    localparam logic [2:0] ST_MUL_Q = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_SEL   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [DIV_W-1:0] divide_count_reg;
    logic [CNT_W-1:0] recovery_delay_reg;
    logic [CNT_W-1:0] full_end_reg;
    logic [CNT_W-1:0] mid_end_reg;
    logic [CNT_W-1:0] last_end_reg;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    rem_reg, rem_next;
    logic [AW-1:0]    sub_reg, sub_next;
    logic [AW-1:0]    quot_reg, quot_next;
    logic             seg_last_reg, seg_last_next;

    logic [DIV_W-1:0] prescale_reg, prescale_next;
    logic [CNT_W-1:0] overload_reg, overload_next;
    logic [CNT_W-1:0] delay_reg, delay_next;
    logic             recovery_reg, recovery_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [LW-1:0]    limit_reg, limit_next;

    logic signed [IN_W-1:0] d_reg, q_reg;

    logic               res_valid_reg, res_valid_next;
    logic [LIMIT_W-1:0] res_limit_reg;
    logic [MAG_W-1:0]   res_mag_reg;
    logic               res_rec_reg;
    logic [CNT_W-1:0]   res_level_reg;
    logic               res_load;

    logic               take;
    logic               out_free;
    logic [DIV_W-1:0]   prescale_inc;
    logic               slow_tick;
    logic [CNT_W-1:0]   oc_upd;
    logic [CNT_W-1:0]   dc_upd;
    logic               rec_upd;

    logic signed [IN_W-1:0]   mul_op;
    logic signed [2*IN_W-1:0] mul_sq;

    logic [AW-1:0]      unit_b;
    logic               unit_ge;
    logic [AW-1:0]      unit_diff;

    logic [CNT_W-1:0]   seg_mid_span;
    logic [CNT_W-1:0]   seg_last_span;
    logic [CNT_W-1:0]   seg_mid_pos;
    logic [CNT_W-1:0]   seg_last_pos;

    olc_cmpsub #(.W(AW)) u_cmpsub (
        .a    (rem_reg),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign out_free     = ~res_valid_reg | result.ready;
    assign sample.ready = (state_reg == ST_IDLE) & out_free;
    assign take         = sample.valid & sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid             = res_valid_reg;
    assign result.current_limit     = res_limit_reg;
    assign result.current_magnitude = res_mag_reg;
    assign result.in_recovery       = res_rec_reg;
    assign result.overload_level    = res_level_reg;

    assign prescale_inc = prescale_reg + DIV_W'(1);
    assign slow_tick    = prescale_inc > divide_count_reg;

    assign mul_op = (state_reg == ST_MUL_D) ? d_reg : q_reg;
    assign mul_sq = mul_op * mul_op;

    assign unit_b = (state_reg == ST_ROOT) ? (quot_reg + sub_reg) : sub_reg;

    assign seg_mid_span  = mid_end_reg - full_end_reg;
    assign seg_last_span = last_end_reg - mid_end_reg;
    assign seg_mid_pos   = overload_reg - full_end_reg;
    assign seg_last_pos  = overload_reg - mid_end_reg;

    always_comb
    begin
        oc_upd  = overload_reg;
        dc_upd  = delay_reg;
        rec_upd = recovery_reg;
        if ({16'd0, mag_reg} > THRESH_PU)
        begin
            if (overload_reg != {CNT_W{1'b1}})
            begin
                oc_upd = overload_reg + CNT_W'(1);
            end
            dc_upd = '0;
        end
        else if (overload_reg != '0)
        begin
            if (delay_reg >= recovery_delay_reg)
            begin
                oc_upd  = overload_reg - CNT_W'(1);
                rec_upd = 1'b1;
            end
            else
            begin
                dc_upd = delay_reg + CNT_W'(1);
            end
        end
        if (rec_upd && (oc_upd == '0))
        begin
            rec_upd = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        sub_next      = sub_reg;
        quot_next     = quot_reg;
        seg_last_next = seg_last_reg;
        prescale_next = prescale_reg;
        overload_next = overload_reg;
        delay_next    = delay_reg;
        recovery_next = recovery_reg;
        mag_next      = mag_reg;
        limit_next    = limit_reg;
        res_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (slow_tick)
                    begin
                        prescale_next = '0;
                        overload_next = oc_upd;
                        delay_next    = dc_upd;
                        recovery_next = rec_upd;
                        state_next    = ST_MUL_D;
                    end
                    else
                    begin
                        prescale_next = prescale_inc;
                        res_load      = 1'b1;
                    end
                end
            end
            ST_MUL_D:
            begin
                rem_next   = AW'($unsigned(mul_sq));
                state_next = ST_MUL_Q;
            end
            ST_MUL_Q:
            begin
                rem_next   = rem_reg + AW'($unsigned(mul_sq));
                sub_next   = AW'(1) << 30;
                quot_next  = '0;
                cnt_next   = CW'(15);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (unit_ge)
                begin
                    rem_next  = unit_diff;
                    quot_next = (quot_reg >> 1) + sub_reg;
                end
                else
                begin
                    quot_next = quot_reg >> 1;
                end
                sub_next = sub_reg >> 2;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                mag_next   = quot_reg[MAG_W-1:0];
                quot_next  = '0;
                cnt_next   = CW'(FRAC_BITS - 1);
                state_next = ST_DONE;
                if (recovery_reg)
                begin
                    limit_next = ONE_PU;
                end
                else if (overload_reg != '0)
                begin
                    if (overload_reg <= full_end_reg)
                    begin
                        limit_next = TWO_PU;
                    end
                    else if (overload_reg <= mid_end_reg)
                    begin
                        rem_next      = (AW'(seg_mid_pos) << FRAC_BITS) + AW'(seg_mid_span);
                        sub_next      = (AW'(seg_mid_span) << 1) << (FRAC_BITS - 1);
                        seg_last_next = 1'b0;
                        state_next    = ST_DIV;
                    end
                    else if (overload_reg <= last_end_reg)
                    begin
                        rem_next      = ((AW'(seg_last_pos) * AW'(3)) << FRAC_BITS)
                                      + AW'(seg_last_span) * AW'(5);
                        sub_next      = (AW'(seg_last_span) * AW'(10)) << (FRAC_BITS - 1);
                        seg_last_next = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        limit_next    = ONE_PU;
                        recovery_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (unit_ge)
                begin
                    rem_next = unit_diff;
                end
                quot_next = {quot_reg[AW-2:0], unit_ge};
                sub_next  = sub_reg >> 1;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                limit_next = (seg_last_reg ? ONEHALF_PU : TWO_PU) - quot_reg[LW-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result.valid && result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divide_count_reg   <= DIV_W'(100);
            recovery_delay_reg <= CNT_W'(100);
            full_end_reg       <= CNT_W'(100);
            mid_end_reg        <= CNT_W'(300);
            last_end_reg       <= CNT_W'(600);
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            prescale_reg       <= '0;
            overload_reg       <= '0;
            delay_reg          <= '0;
            recovery_reg       <= 1'b0;
            mag_reg            <= '0;
            limit_reg          <= TWO_PU;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_DIVIDE_COUNT:      divide_count_reg   <= cfg.data[DIV_W-1:0];
                    REG_RECOVERY_DELAY:    recovery_delay_reg <= cfg.data;
                    REG_FULL_OVERLOAD_END: full_end_reg       <= cfg.data;
                    REG_MID_OVERLOAD_END:  mid_end_reg        <= cfg.data;
                    REG_LAST_OVERLOAD_END: last_end_reg       <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prescale_reg  <= prescale_next;
            overload_reg  <= overload_next;
            delay_reg     <= delay_next;
            recovery_reg  <= recovery_next;
            mag_reg       <= mag_next;
            limit_reg     <= limit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        sub_reg      <= sub_next;
        quot_reg     <= quot_next;
        seg_last_reg <= seg_last_next;
        if (take)
        begin
            d_reg <= sample.current_d;
            q_reg <= sample.current_q;
        end
        if (res_load)
        begin
            res_limit_reg <= LIMIT_W'(limit_next);
            res_mag_reg   <= mag_next;
            res_rec_reg   <= recovery_next;
            res_level_reg <= overload_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/olc_checker.sv
`default_nettype none
`include "inverter_overload_current_limiter_macros.svh"

module olc_checker import olc_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               sample_valid,
    input wire logic               sample_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic [LIMIT_W-1:0] result_limit,
    input wire logic               result_recovery,
    input wire logic [CNT_W-1:0]   result_level
);

    localparam logic [LIMIT_W-1:0] ONE_LIMIT = LIMIT_W'(32'd1 << FRAC_BITS);

    // A stalled result keeps its slot and its limit.
    `OLC_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_limit), "result dropped or changed while stalled")

    // While a result is held, a new sample is taken only when the result slot drains in the same cycle.
    `OLC_ASSERT_IMP(a_slot_free, sample_valid && sample_ready && result_valid, result_ready, "sample taken while result slot is blocked")

    // Recovery always comes with the nominal limit.
    `OLC_ASSERT_IMP(a_recovery_limit, result_valid && result_recovery, result_limit == ONE_LIMIT, "recovery reported with a limit other than 1.0 pu")

    // Recovery ends once the overload count has run down.
    `OLC_ASSERT_IMP(a_recovery_count, result_valid && (result_level == '0), !result_recovery, "recovery reported with an empty overload count")

endmodule

bind inverter_overload_current_limiter olc_checker #(.FRAC_BITS(FRAC_BITS)) u_olc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_valid    (sample.valid),
    .sample_ready    (sample.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_limit    (result.current_limit),
    .result_recovery (result.in_recovery),
    .result_level    (result.overload_level)
);

`default_nettype wire

FILE: tb/tb_inverter_overload_current_limiter.sv
`timescale 1ns / 100ps

module tb_inverter_overload_current_limiter;
    import olc_pkg::*;

    localparam int FRAC        = 12;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    typedef enum int {KIND_HIGH, KIND_LOW, KIND_NEAR, KIND_NOISE} drive_kind_t;

    typedef struct {
        logic [LIMIT_W-1:0] limit;
        logic [MAG_W-1:0]   magnitude;
        logic               recovery;
        logic [CNT_W-1:0]   level;
    } limiter_out_t;

    class olc_scoreboard;
        int unsigned  divide_count;
        int unsigned  recovery_delay;
        int unsigned  full_end;
        int unsigned  mid_end;
        int unsigned  last_end;
        int unsigned  prescale;
        int unsigned  overload;
        int unsigned  delay_cnt;
        int unsigned  magnitude;
        int unsigned  limit;
        bit           recovery;
        limiter_out_t expected_outs[$];
        int           errors;
        int           ticks;
        int           slow_updates;
        int           recovery_entries;
        int unsigned  peak_overload;

        function new();
            divide_count     = 100;
            recovery_delay   = 100;
            full_end         = 100;
            mid_end          = 300;
            last_end         = 600;
            prescale         = 0;
            overload         = 0;
            delay_cnt        = 0;
            magnitude        = 0;
            limit            = 2 << FRAC;
            recovery         = 0;
            errors           = 0;
            ticks            = 0;
            slow_updates     = 0;
            recovery_entries = 0;
            peak_overload    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, int unsigned value);
            case (idx)
                REG_DIVIDE_COUNT:      divide_count   = value & 'hFF;
                REG_RECOVERY_DELAY:    recovery_delay = value & 'hFFFF;
                REG_FULL_OVERLOAD_END: full_end       = value & 'hFFFF;
                REG_MID_OVERLOAD_END:  mid_end        = value & 'hFFFF;
                REG_LAST_OVERLOAD_END: last_end       = value & 'hFFFF;
                default: ;
            endcase
        endfunction

        function int unsigned root_floor(longint unsigned v);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe >>= 2;
            while (probe != 0)
            begin
                if (v >= root + probe)
                begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                begin
                    root >>= 1;
                end
                probe >>= 2;
            end
            return 32'(root);
        endfunction

        function void slow_update(logic signed [IN_W-1:0] d, logic signed [IN_W-1:0] q);
            longint unsigned thresh;
            longint unsigned sum;
            longint unsigned num;
            longint unsigned den;
            longint unsigned rounded;
            longint          sd;
            longint          sq;
            int unsigned     c;
            bit              was_recovering;
            was_recovering = recovery;
            thresh = (longint'(102) << FRAC) / 100;
            if (magnitude > thresh)
            begin
                if (overload < 'hFFFF)
                    overload++;
                delay_cnt = 0;
            end
            else if (overload > 0)
            begin
                if (delay_cnt >= recovery_delay)
                begin
                    overload--;
                    recovery = 1;
                end
                else
                begin
                    delay_cnt = (delay_cnt + 1) & 'hFFFF;
                end
            end
            if (recovery && overload == 0)
                recovery = 0;

            sd  = d;
            sq  = q;
            sum = sd * sd + sq * sq;
            magnitude = root_floor(sum);
            if (magnitude > 'hFFFF)
                magnitude = 'hFFFF;

            c = overload;
            if (recovery)
            begin
                limit = 1 << FRAC;
            end
            else if (c > 0)
            begin
                if (c <= full_end)
                begin
                    limit = 2 << FRAC;
                end
                else if (c <= mid_end)
                begin
                    num     = longint'(c - full_end) << FRAC;
                    den     = 2 * longint'(mid_end - full_end);
                    rounded = (num + den / 2) / den;
                    limit   = 32'((2 << FRAC) - rounded);
                end
                else if (c <= last_end)
                begin
                    num     = (3 * longint'(c - mid_end)) << FRAC;
                    den     = 10 * longint'(last_end - mid_end);
                    rounded = (num + den / 2) / den;
                    limit   = 32'(3 * (1 << (FRAC - 1)) - rounded);
                end
                else
                begin
                    limit    = 1 << FRAC;
                    recovery = 1;
                end
            end
            if (recovery && !was_recovering)
                recovery_entries++;
            if (overload > peak_overload)
                peak_overload = overload;
        endfunction

        function void note_tick(logic signed [IN_W-1:0] d, logic signed [IN_W-1:0] q);
            limiter_out_t o;
            ticks++;
            prescale = (prescale + 1) & 'hFF;
            if (prescale > divide_count)
            begin
                prescale = 0;
                slow_updates++;
                slow_update(d, q);
            end
            o.limit     = LIMIT_W'(limit);
            o.magnitude = MAG_W'(magnitude);
            o.recovery  = recovery;
            o.level     = CNT_W'(overload);
            expected_outs.push_back(o);
        endfunction

        function void check_out(logic [LIMIT_W-1:0] lim, logic [MAG_W-1:0] mag,
                                logic rec, logic [CNT_W-1:0] lvl);
            limiter_out_t e;
            if (expected_outs.size() == 0)
            begin
                $error("result transfer with no tick pending: current_limit %0d", lim);
                errors++;
                return;
            end
            e = expected_outs.pop_front();
            if (lim !== e.limit)
            begin
                $error("current_limit expected %0d actual %0d", e.limit, lim);
                errors++;
            end
            if (mag !== e.magnitude)
            begin
                $error("current_magnitude expected %0d actual %0d", e.magnitude, mag);
                errors++;
            end
            if (rec !== e.recovery)
            begin
                $error("in_recovery expected %0d actual %0d", e.recovery, rec);
                errors++;
            end
            if (lvl !== e.level)
            begin
                $error("overload_level expected %0d actual %0d", e.level, lvl);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    olc_sample_if sample_ch ();
    olc_result_if result_ch ();
    olc_cfg_if    cfg_ch ();

    olc_scoreboard sb;
    bit            hold_req;
    int            hold_left;
    int            stall_mode;
    int            mode_left;
    int            setting_count;

    inverter_overload_current_limiter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_tick(logic signed [IN_W-1:0] d, logic signed [IN_W-1:0] q);
        sample_ch.valid     <= 1'b1;
        sample_ch.current_d <= d;
        sample_ch.current_q <= q;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_tick(d, q);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(int unsigned div, int unsigned delay, int unsigned full,
                             int unsigned mid, int unsigned last);
        write_reg(REG_DIVIDE_COUNT, div);
        write_reg(REG_RECOVERY_DELAY, delay);
        write_reg(REG_FULL_OVERLOAD_END, full);
        write_reg(REG_MID_OVERLOAD_END, mid);
        write_reg(REG_LAST_OVERLOAD_END, last);
        cfg_ch.valid <= 1'b0;
        setting_count++;
    endtask

    task automatic drain();
        while (sb.expected_outs.size() != 0)
            @(posedge clk);
    endtask

    function automatic void make_currents(drive_kind_t kind, output logic signed [IN_W-1:0] d,
                                          output logic signed [IN_W-1:0] q);
        int  a;
        int  b;
        logic signed [IN_W-1:0] t;
        case (kind)
            KIND_HIGH:
            begin
                a = $urandom_range(4300, 32767);
                d = IN_W'($urandom_range(0, 1) ? -a : a);
                q = IN_W'($urandom);
            end
            KIND_LOW:
            begin
                a = $urandom_range(0, 5900);
                b = $urandom_range(0, 5900);
                d = IN_W'(a - 2950);
                q = IN_W'(b - 2950);
            end
            KIND_NEAR:
            begin
                a = $urandom_range(4175, 4180);
                b = $urandom_range(0, 2);
                d = IN_W'($urandom_range(0, 1) ? -a : a);
                q = IN_W'($urandom_range(0, 1) ? -b : b);
            end
            default:
            begin
                d = IN_W'($urandom);
                q = IN_W'($urandom);
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            t = d;
            d = q;
            q = t;
        end
    endfunction

    task automatic run_ticks(int n, bit gaps_on);
        int                     left;
        int                     burst;
        int                     seq_left;
        int                     pick;
        drive_kind_t            kind;
        logic signed [IN_W-1:0] d;
        logic signed [IN_W-1:0] q;
        left     = n;
        seq_left = 0;
        kind     = KIND_NOISE;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                if (seq_left == 0)
                begin
                    pick     = $urandom_range(0, 9);
                    kind     = (pick < 4) ? KIND_HIGH : (pick < 7) ? KIND_LOW :
                               (pick < 8) ? KIND_NEAR : KIND_NOISE;
                    seq_left = $urandom_range(1, 30);
                end
                seq_left--;
                make_currents(kind, d, q);
                send_tick(d, q);
                left--;
            end
            if (left > 0 && gaps_on && $urandom_range(0, 2) != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        sample_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned div, int unsigned delay, int unsigned full,
                             int unsigned mid, int unsigned last, int n, bit gaps_on);
        drain();
        configure(div, delay, full, mid, last);
        run_ticks(n, gaps_on);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_out(result_ch.current_limit, result_ch.current_magnitude,
                         result_ch.in_recovery, result_ch.overload_level);
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 300);
        end
        else
        begin
            mode_left--;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= 1'($urandom_range(0, 1));
                default: result_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("inverter_overload_current_limiter: mismatch");
        $finish;
    end

    initial
    begin
        sb                  = new();
        hold_req            = 1'b0;
        hold_left           = 0;
        stall_mode          = 0;
        mode_left           = 0;
        setting_count       = 0;
        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.current_d = '0;
        sample_ch.current_q = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_DIVIDE_COUNT;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        repeat (3) send_tick(16'sd4000, -16'sd4000);
        sample_ch.valid <= 1'b0;
        drain();
        configure(0, 0, 1, 3, 5);
        send_tick(-16'sd32768, -16'sd32768);
        send_tick(16'sd32767, 16'sd32767);
        send_tick(-16'sd32768, 16'sd32767);
        send_tick(16'sd0, 16'sd0);
        send_tick(16'sd4177, 16'sd0);
        send_tick(16'sd4178, 16'sd0);
        send_tick(16'sd0, -16'sd4178);
        repeat (8) send_tick(16'sd20000, -16'sd3);
        repeat (8) send_tick(16'sd100, -16'sd100);
        sample_ch.valid <= 1'b0;

        run_phase(0, 0, 0, 0, 0, 120, 1'b1);
        run_phase(1, 2, 4, 10, 20, 120, 1'b1);

        // The receiver backs off for a long stretch while ticks keep coming without gaps.
        drain();
        configure(0, 5, 10, 30, 50);
        hold_req = 1'b1;
        run_ticks(250, 1'b0);

        run_phase(255, 65535, 65535, 65535, 65535, 120, 1'b1);
        run_phase(0, 65535, 65535, 65535, 65535, 150, 1'b0);
        run_phase(0, 1, 20, 5, 40, 120, 1'b1);
        run_phase(0, 3, 8, 8, 8, 150, 1'b1);
        run_phase(2, 0, 2, 30, 25, 150, 1'b1);
        run_phase(100, 100, 100, 300, 600, 150, 1'b1);
        repeat (2)
            run_phase($urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 15),
                      $urandom_range(0, 40), $urandom_range(0, 80), 100, 1'b1);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Ran %0d ticks over %0d settings with %0d slow updates.",
                 sb.ticks, setting_count, sb.slow_updates);
        $display("Recovery was entered %0d times; the overload count peaked at %0d.",
                 sb.recovery_entries, sb.peak_overload);
        if (sb.errors == 0 && sb.expected_outs.size() == 0)
            $display("inverter_overload_current_limiter: match");
        else
            $display("inverter_overload_current_limiter: mismatch");
        $finish;
    end

endmodule
